// ----- hdl/sme_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the stack machine executor.
package sme_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int WORD_WIDTH  = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int OPC_W       = 8;

  localparam logic [OPC_W-1:0] OP_PUSH  = OPC_W'(1);
  localparam logic [OPC_W-1:0] OP_ADD   = OPC_W'(2);
  localparam logic [OPC_W-1:0] OP_SUB   = OPC_W'(3);
  localparam logic [OPC_W-1:0] OP_MUL   = OPC_W'(4);
  localparam logic [OPC_W-1:0] OP_DIV   = OPC_W'(5);
  localparam logic [OPC_W-1:0] OP_EMIT  = OPC_W'(6);
  localparam logic [OPC_W-1:0] OP_HALT  = OPC_W'(7);

  typedef enum logic [2:0] {
    CLS_PUSH, CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV, CLS_PRINT, CLS_HALT, CLS_BAD
  } cls_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_DIVZERO   = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_RUN, MODE_HALT, MODE_FAULT
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE, S_EXEC, S_DIV, S_FIN
  } state_t;

  typedef struct packed {
    cls_t                  cls;
    logic [WORD_WIDTH-1:0] operand;
    logic                  last;
  } instr_t;

  typedef struct packed {
    status_t               status;
    logic [WORD_WIDTH-1:0] top_value;
    logic                  top_valid;
    logic [CNT_W-1:0]      stack_depth;
    logic                  print_strobe;
    logic                  end_of_program;
  } result_t;

endpackage

// ----- hdl/stack_machine_executor_top.sv -----
`timescale 1ns / 1ps
// Top level of the stack machine executor.
//
// One instruction word enters on the s_axis channel; exactly one result word
// leaves on the m_axis channel for each, in order. s_axis_tlast marks the last
// instruction of a program; its result carries m_axis_tlast and the stack and
// run mode are cleared right after it.
// A two-entry queue decouples input acceptance from execution, so up to two
// words are taken while the executor is busy or the output is stalled.
// An idle block takes a word in S_IDLE, which issues the stack read, and
// executes it in S_EXEC, which loads the result register; no new word is taken
// until then, due to the registered stack read (issue read, then execute and
// write back). DIV holds the executor while the divider makes one bit per cycle.
// The result sits in an output register; when m_axis_tready is low the
// executor finishes the next instruction and holds it until the register frees,
// and the queue then fills and drops s_axis_tready.
// Reset (rst, synchronous) empties the queue, the stack and the output register
// and puts the machine in running mode; the stack memory needs no clearing.
module stack_machine_executor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // req_type[7:0], operand_value[39:8]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // status[2:0], top_value[34:3], top_valid[35],
                                      // stack_depth[44:36], print_strobe[45], zero[47:46]
  output logic        m_axis_tlast
);

  logic             q_valid;
  logic             q_ready;
  sme_pkg::instr_t  q_data;
  sme_pkg::result_t res;

  sme_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .req_type        (s_axis_tdata[7:0]),
    .operand_value   (s_axis_tdata[39:8]),
    .last_of_program (s_axis_tlast),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_data          (q_data)
  );

  sme_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (res)
  );

  assign m_axis_tdata = {2'b00, res.print_strobe, res.stack_depth, res.top_valid,
                         res.top_value, res.status};
  assign m_axis_tlast = res.end_of_program;

`ifndef ASSERT_OFF
  a_print_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[45]) |->
      (m_axis_tdata[2:0] == sme_pkg::ST_OK && m_axis_tdata[35]))
    else $error("print strobe without ok status and nonempty stack");

  a_depth_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[44:36] <= 9'(sme_pkg::STACK_DEPTH)))
    else $error("stack depth beyond capacity");

  a_full_queue: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid)
    else $error("input stalled with empty queue");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> !q_ready)
    else $error("executor took a second word before finishing the first");
`endif

endmodule

// ----- hdl/sme_front.sv -----
`timescale 1ns / 1ps
// Front end: opcode decode and a two-entry instruction queue.
module sme_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sme_pkg::OPC_W-1:0]        req_type,
  input  logic [sme_pkg::WORD_WIDTH-1:0]   operand_value,
  input  logic                             last_of_program,
  output logic                             q_valid,
  input  logic                             q_ready,
  output sme_pkg::instr_t                  q_data
);

  localparam int QD     = 2;
  localparam int PTR_W  = $clog2(QD);
  localparam int FILL_W = $clog2(QD + 1);

  sme_pkg::instr_t  queue [QD];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [FILL_W-1:0] fill;
  sme_pkg::instr_t  dec;
  logic             push;
  logic             pop;

  always_comb begin
    unique case (req_type)
      sme_pkg::OP_PUSH:  dec.cls = sme_pkg::CLS_PUSH;
      sme_pkg::OP_ADD:   dec.cls = sme_pkg::CLS_ADD;
      sme_pkg::OP_SUB:   dec.cls = sme_pkg::CLS_SUB;
      sme_pkg::OP_MUL:   dec.cls = sme_pkg::CLS_MUL;
      sme_pkg::OP_DIV:   dec.cls = sme_pkg::CLS_DIV;
      sme_pkg::OP_EMIT:  dec.cls = sme_pkg::CLS_PRINT;
      sme_pkg::OP_HALT:  dec.cls = sme_pkg::CLS_HALT;
      default:           dec.cls = sme_pkg::CLS_BAD;
    endcase
    dec.operand = operand_value;
    dec.last    = last_of_program;
  end

  assign in_ready = (fill != FILL_W'(QD));
  assign q_valid  = (fill != '0);
  assign q_data   = queue[rd_ptr];
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// ----- hdl/sme_div.sv -----
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sme_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sme_pkg::WORD_WIDTH-1:0] dividend,
  input  logic [sme_pkg::WORD_WIDTH-1:0] divisor,
  output logic                           done,
  output logic [sme_pkg::WORD_WIDTH-1:0] quotient
);

  localparam int W      = sme_pkg::WORD_WIDTH;
  localparam int STEP_W = $clog2(W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [W-1:0]      rem;
  logic [W-1:0]      quo;
  logic [W-1:0]      dvs;
  logic              neg;
  logic [W-1:0]      a_mag;
  logic [W-1:0]      b_mag;
  logic [W:0]        trial;
  logic [W:0]        diff;
  logic              fits;
  logic [W-1:0]      rem_next;
  logic [W-1:0]      quo_next;

  always_comb begin
    a_mag    = dividend[W-1] ? (W'(0) - dividend) : dividend;
    b_mag    = divisor[W-1] ? (W'(0) - divisor) : divisor;
    trial    = {rem, quo[W-1]};
    diff     = trial - {1'b0, dvs};
    fits     = ~diff[W];
    rem_next = fits ? diff[W-1:0] : trial[W-1:0];
    quo_next = {quo[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= a_mag;
      dvs <= b_mag;
      neg <= dividend[W-1] ^ divisor[W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      if (step == STEP_W'(W - 1)) begin
        quotient <= neg ? (W'(0) - quo_next) : quo_next;
      end
    end
  end

endmodule

// ----- hdl/sme_back.sv -----
`timescale 1ns / 1ps
// Back end: stack memory, top-of-stack register, execute sequencer, result register.
module sme_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sme_pkg::instr_t      q_data,
  output logic                 m_valid,
  input  logic                 m_ready,
  output sme_pkg::result_t     m_data
);

  localparam int W      = sme_pkg::WORD_WIDTH;
  localparam int CNT_W  = sme_pkg::CNT_W;
  localparam int ADDR_W = sme_pkg::ADDR_W;

  logic [W-1:0]        stack_mem [sme_pkg::STACK_DEPTH];
  sme_pkg::state_t     state;
  sme_pkg::state_t     state_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_new;
  sme_pkg::mode_t      mode;
  sme_pkg::mode_t      mode_new;
  logic [W-1:0]        top;
  logic [W-1:0]        top_new;
  sme_pkg::instr_t     ins;
  logic [W-1:0]        rd_a;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    cnt_m2;
  logic                rd_en;
  logic                push_wr;
  logic                wr_en;
  logic                commit;
  logic                out_free;
  sme_pkg::status_t    status;
  logic                strobe;
  logic [W-1:0]        prod_lo;
  logic                div_start;
  logic                div_done;
  logic [W-1:0]        div_quo;
  logic                out_valid;
  sme_pkg::result_t    out_data;
  sme_pkg::result_t    res;

  sme_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_a),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign prod_lo  = rd_a * top;
  assign out_free = ~out_valid | m_ready;
  assign wr_en    = push_wr & commit;
  assign m_valid  = out_valid;
  assign m_data   = out_data;

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    rd_en      = 1'b0;
    push_wr    = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    status     = sme_pkg::ST_OK;
    strobe     = 1'b0;
    count_new  = count;
    top_new    = top;
    mode_new   = mode;
    unique case (state)
      sme_pkg::S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          rd_en      = 1'b1;
          state_next = sme_pkg::S_EXEC;
        end
      end
      sme_pkg::S_EXEC: begin
        if (mode != sme_pkg::MODE_RUN) begin
          status = sme_pkg::ST_IGNORED;
        end else begin
          case (ins.cls) inside
            sme_pkg::CLS_PUSH: begin
              if (count == CNT_W'(sme_pkg::STACK_DEPTH)) begin
                status = sme_pkg::ST_OVERFLOW;
              end else begin
                push_wr   = (count != '0);
                top_new   = ins.operand;
                count_new = count + CNT_W'(1);
              end
            end
            sme_pkg::CLS_ADD, sme_pkg::CLS_SUB, sme_pkg::CLS_MUL, sme_pkg::CLS_DIV: begin
              if (count < CNT_W'(2)) begin
                status = sme_pkg::ST_UNDERFLOW;
              end else begin
                count_new = cnt_m1;
                case (ins.cls)
                  sme_pkg::CLS_ADD: top_new = rd_a + top;
                  sme_pkg::CLS_SUB: top_new = rd_a - top;
                  sme_pkg::CLS_MUL: top_new = prod_lo;
                  default: begin
                    if (top == '0) begin
                      status    = sme_pkg::ST_DIVZERO;
                      count_new = count;
                    end else begin
                      div_start = 1'b1;
                    end
                  end
                endcase
              end
            end
            sme_pkg::CLS_PRINT: begin
              if (count == '0) begin
                status = sme_pkg::ST_UNDERFLOW;
              end else begin
                strobe = 1'b1;
              end
            end
            sme_pkg::CLS_HALT: begin
              status   = sme_pkg::ST_IGNORED;
              mode_new = sme_pkg::MODE_HALT;
            end
            default: begin
              status = sme_pkg::ST_UNKNOWN;
            end
          endcase
        end
        if (status >= sme_pkg::ST_OVERFLOW) begin
          mode_new = sme_pkg::MODE_FAULT;
        end
        if (div_start) begin
          state_next = sme_pkg::S_DIV;
        end else if (out_free) begin
          commit     = 1'b1;
          state_next = sme_pkg::S_IDLE;
        end
      end
      sme_pkg::S_DIV: begin
        if (div_done) begin
          state_next = sme_pkg::S_FIN;
        end
      end
      sme_pkg::S_FIN: begin
        top_new   = div_quo;
        count_new = cnt_m1;
        if (out_free) begin
          commit     = 1'b1;
          state_next = sme_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sme_pkg::S_IDLE;
      end
    endcase

    res.status         = status;
    res.top_value      = (count_new != '0) ? top_new : '0;
    res.top_valid      = (count_new != '0);
    res.stack_depth    = count_new;
    res.print_strobe   = strobe;
    res.end_of_program = ins.last;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[cnt_m1[ADDR_W-1:0]] <= top;
    end
    if (rd_en) begin
      rd_a <= stack_mem[cnt_m2[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sme_pkg::S_IDLE;
      count     <= '0;
      mode      <= sme_pkg::MODE_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= ins.last ? '0 : count_new;
        mode      <= ins.last ? sme_pkg::MODE_RUN : mode_new;
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      ins <= q_data;
    end
    if (commit) begin
      top      <= top_new;
      out_data <= res;
    end
  end

endmodule
